// ===== src/fir_convolution_reflect_border_macros.svh =====
// ----------------------------------------------------------------------------
// fir_convolution_reflect_border assertion macros
// shorthand for the concurrent checks on the filter ports
// ----------------------------------------------------------------------------
`ifndef FIR_CONVOLUTION_REFLECT_BORDER_MACROS_SVH
`define FIR_CONVOLUTION_REFLECT_BORDER_MACROS_SVH

// same-cycle implication, masked while in reset
`define FCRB_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, masked while in reset
`define FCRB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication that also holds across reset
`define FCRB_ASSERT_NEXT_ALWAYS(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/fcrb_pkg.sv =====
// ----------------------------------------------------------------------------
// fcrb_pkg
// shared constants and types of the reflected-border symmetric fir filter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fcrb_pkg;

  localparam int MAX_RADIUS = 5;
  localparam int MAX_ROW    = 4096;

  localparam int SAMPLE_W = 16;
  localparam int COEF_W   = 16;
  localparam int RAD_W    = 3;
  localparam int MODE_W   = 2;
  localparam int NCOEF    = 6;
  localparam int CFG_IDX_W = 3;

  // usable radius is bounded by the window and by the coefficient registers
  localparam int RAD_CAP   = (MAX_RADIUS < NCOEF - 1) ? MAX_RADIUS : NCOEF - 1;
  localparam int NUSED     = RAD_CAP + 1;
  localparam int NTAP      = 2 * RAD_CAP + 1;
  localparam int WIN_LEN   = 2 * MAX_RADIUS + 1;
  localparam int OFF_IDX_W = $clog2(WIN_LEN);
  localparam int CNT_W     = $clog2(MAX_ROW + 1);
  localparam int PEND_W    = $clog2(RAD_CAP + 2);
  localparam int D_W       = RAD_W + 2;
  localparam int OFF_W     = CNT_W + 2;

  localparam int TAP_W  = SAMPLE_W + 1;
  localparam int PSUM_W = SAMPLE_W + 2;
  localparam int PROD_W = COEF_W + 1 + PSUM_W;
  localparam int ACC_W  = PROD_W + $clog2(NUSED) + 1;
  localparam int HALF   = (NUSED + 1) / 2;

  localparam int FRAC_W     = 16;
  localparam int ROUND_BIAS = 1 << (FRAC_W - 1);
  localparam int Y_W        = ACC_W - FRAC_W;
  localparam int SAT_MAX    = (1 << (SAMPLE_W - 1)) - 1;
  localparam int SAT_MIN    = -(1 << (SAMPLE_W - 1));

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RADIUS = 3'd0,
    CFG_BORDER = 3'd1,
    CFG_COEF0  = 3'd2,
    CFG_COEF1  = 3'd3,
    CFG_COEF2  = 3'd4,
    CFG_COEF3  = 3'd5,
    CFG_COEF4  = 3'd6,
    CFG_COEF5  = 3'd7
  } cfg_idx_t;

  typedef enum logic [MODE_W-1:0] {
    BORDER_ZERO   = 2'd0,
    BORDER_MIRROR = 2'd1,
    BORDER_NEGATE = 2'd2
  } border_t;

  typedef logic [SAMPLE_W-1:0]                 sample_t;
  typedef sample_t [WIN_LEN-1:0]               window_t;
  typedef logic [NCOEF-1:0][COEF_W-1:0]        coef_arr_t;
  typedef logic signed [NUSED-1:0][PSUM_W-1:0] psum_arr_t;

  localparam coef_arr_t COEF_RESET = {{(NCOEF-1){16'h0000}}, 16'hffff};

  typedef struct packed {
    logic last;
    logic short_row;
  } fcrb_tag_t;

endpackage

// ===== src/fcrb_tap_sel.sv =====
// ----------------------------------------------------------------------------
// fcrb_tap_sel
// picks each kernel tap from the sample window, applies border reflection and
// adds the symmetric tap pairs
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fcrb_tap_sel (
  input  fcrb_pkg::window_t             win,
  input  logic [fcrb_pkg::CNT_W-1:0]    n,      // samples of the row so far
  input  logic [fcrb_pkg::RAD_W-1:0]    e,      // distance of output from newest sample
  input  logic                          closed, // row end seen, right border known
  input  logic [fcrb_pkg::RAD_W-1:0]    r,
  input  logic [fcrb_pkg::MODE_W-1:0]   mode,
  output fcrb_pkg::psum_arr_t           psum
);

  logic signed [fcrb_pkg::TAP_W-1:0] tap_v [fcrb_pkg::NTAP];

  for (genvar t = 0; t < fcrb_pkg::NTAP; t++) begin : g_tap
    localparam int K = t - fcrb_pkg::RAD_CAP;
    localparam int A = (K < 0) ? -K : K;

    logic signed [fcrb_pkg::D_W-1:0]   d;
    logic signed [fcrb_pkg::OFF_W-1:0] d_ext;
    logic signed [fcrb_pkg::OFF_W-1:0] n_ext;
    logic signed [fcrb_pkg::OFF_W-1:0] off;
    logic                              refl;
    logic                              ok;
    logic signed [fcrb_pkg::TAP_W-1:0] s;

    always_comb begin
      // d is the window offset without any border
      d     = $signed({2'b00, e}) - $signed(fcrb_pkg::D_W'(K));
      d_ext = fcrb_pkg::OFF_W'(d);
      n_ext = $signed({2'b00, n});
      refl  = 1'b0;
      ok    = 1'b1;
      if (d[fcrb_pkg::D_W-1]) begin
        // past the row end: mirror about the last sample
        off  = -fcrb_pkg::OFF_W'(1) - d_ext;
        refl = 1'b1;
        ok   = closed;
      end else if (d_ext >= n_ext) begin
        // before the row start: mirror about the first sample
        off  = (n_ext <<< 1) - fcrb_pkg::OFF_W'(1) - d_ext;
        refl = 1'b1;
      end else begin
        off = d_ext;
      end
      if (off < 0 || off >= fcrb_pkg::OFF_W'(fcrb_pkg::WIN_LEN)) begin
        ok = 1'b0;
      end
      if (fcrb_pkg::RAD_W'(A) > r) begin
        ok = 1'b0;
      end
      s = ok ? fcrb_pkg::TAP_W'($signed(win[off[fcrb_pkg::OFF_IDX_W-1:0]])) : '0;
      if (!refl) begin
        tap_v[t] = s;
      end else begin
        case (mode)
          fcrb_pkg::BORDER_MIRROR: tap_v[t] = s;
          fcrb_pkg::BORDER_NEGATE: tap_v[t] = -s;
          default:                 tap_v[t] = '0;
        endcase
      end
    end
  end

  always_comb begin
    psum[0] = fcrb_pkg::PSUM_W'(tap_v[fcrb_pkg::RAD_CAP]);
    for (int a = 1; a < fcrb_pkg::NUSED; a++) begin
      psum[a] = fcrb_pkg::PSUM_W'(tap_v[fcrb_pkg::RAD_CAP - a])
              + fcrb_pkg::PSUM_W'(tap_v[fcrb_pkg::RAD_CAP + a]);
    end
  end

endmodule

// ===== src/fcrb_mac.sv =====
// ----------------------------------------------------------------------------
// fcrb_mac
// weights the paired taps, sums, rounds and saturates; three register stages
// with the output register last
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fcrb_mac (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          s_valid,
  output logic                          s_ready,
  input  fcrb_pkg::psum_arr_t           s_psum,
  input  fcrb_pkg::fcrb_tag_t           s_tag,
  input  fcrb_pkg::coef_arr_t           coef,
  output logic                          m_valid,
  input  logic                          m_ready,
  output logic [fcrb_pkg::SAMPLE_W-1:0] m_sample,
  output fcrb_pkg::fcrb_tag_t           m_tag
);

  logic signed [fcrb_pkg::PROD_W-1:0] prod_r [fcrb_pkg::NUSED];
  logic signed [fcrb_pkg::PROD_W-1:0] prod_nxt [fcrb_pkg::NUSED];
  fcrb_pkg::fcrb_tag_t                b_tag_r;
  logic                               b_valid_r;
  logic                               b_ready;

  logic signed [fcrb_pkg::ACC_W-1:0]  part0_r, part1_r;
  logic signed [fcrb_pkg::ACC_W-1:0]  part0_nxt, part1_nxt;
  fcrb_pkg::fcrb_tag_t                c_tag_r;
  logic                               c_valid_r;
  logic                               c_ready;

  logic [fcrb_pkg::SAMPLE_W-1:0]      out_sample_r, out_sample_nxt;
  fcrb_pkg::fcrb_tag_t                out_tag_r;
  logic                               out_valid_r;
  logic                               d_ready;

  logic signed [fcrb_pkg::ACC_W-1:0]  acc;
  logic signed [fcrb_pkg::Y_W-1:0]    y;

  assign d_ready = !out_valid_r || m_ready;
  assign c_ready = !c_valid_r || d_ready;
  assign b_ready = !b_valid_r || c_ready;
  assign s_ready = b_ready;

  // an element of the packed pair array selects as unsigned
  always_comb begin
    for (int a = 0; a < fcrb_pkg::NUSED; a++) begin
      prod_nxt[a] = $signed({1'b0, coef[a]}) * $signed(s_psum[a]);
    end
  end

  always_comb begin
    part0_nxt = '0;
    part1_nxt = '0;
    for (int a = 0; a < fcrb_pkg::NUSED; a++) begin
      if (a < fcrb_pkg::HALF) begin
        part0_nxt = part0_nxt + fcrb_pkg::ACC_W'(prod_r[a]);
      end else begin
        part1_nxt = part1_nxt + fcrb_pkg::ACC_W'(prod_r[a]);
      end
    end
  end

  // round half up to Q8.8, then clamp
  always_comb begin
    acc = part0_r + part1_r + fcrb_pkg::ACC_W'(fcrb_pkg::ROUND_BIAS);
    y   = acc[fcrb_pkg::ACC_W-1:fcrb_pkg::FRAC_W];
    if (c_tag_r.short_row) begin
      out_sample_nxt = '0;
    end else if (y > fcrb_pkg::Y_W'(fcrb_pkg::SAT_MAX)) begin
      out_sample_nxt = fcrb_pkg::SAMPLE_W'(fcrb_pkg::SAT_MAX);
    end else if (y < fcrb_pkg::Y_W'(fcrb_pkg::SAT_MIN)) begin
      out_sample_nxt = fcrb_pkg::SAMPLE_W'(fcrb_pkg::SAT_MIN);
    end else begin
      out_sample_nxt = y[fcrb_pkg::SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r   <= 1'b0;
      c_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (b_ready) begin
        b_valid_r <= s_valid;
      end
      if (c_ready) begin
        c_valid_r <= b_valid_r;
      end
      if (d_ready) begin
        out_valid_r <= c_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (b_ready && s_valid) begin
      prod_r  <= prod_nxt;
      b_tag_r <= s_tag;
    end
    if (c_ready && b_valid_r) begin
      part0_r <= part0_nxt;
      part1_r <= part1_nxt;
      c_tag_r <= b_tag_r;
    end
    if (d_ready && c_valid_r) begin
      out_sample_r <= out_sample_nxt;
      out_tag_r    <= c_tag_r;
    end
  end

  assign m_valid  = out_valid_r;
  assign m_sample = out_sample_r;
  assign m_tag    = out_tag_r;

endmodule

// ===== src/fir_convolution_reflect_border.sv =====
// ----------------------------------------------------------------------------
// fir_convolution_reflect_border
// symmetric fir filter over a row of Q8.8 samples with reflected row borders
// ----------------------------------------------------------------------------
// Takes one sample word per clock unless held off. Output j leaves when
// sample j+radius comes in; the row-end word makes the block emit the
// held-back outputs, up to radius+1 words, one per clock from the issue
// register unless the result side stalls, and input is held off while they
// go out (the issue register is the limit). A row shorter than the radius
// gives a single word with tuser set and data zero. A word goes through four
// registers (issue, tap pairs, products, partial sums) before the output
// register. Configuration writes are taken at any time but must only be made
// while no word is in flight.
`timescale 1ns / 1ps

module fir_convolution_reflect_border (
  input  logic                           clk,
  input  logic                           rst_n,
  // input stream
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [fcrb_pkg::SAMPLE_W-1:0]  in_tdata,   // [15:0] sample_in
  input  logic                           in_tlast,   // row_end
  // result stream
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [fcrb_pkg::SAMPLE_W-1:0]  out_tdata,  // [15:0] sample_out
  output logic                           out_tlast,  // last_out
  output logic                           out_tuser,  // [0] short_row
  // register writes
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [fcrb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fcrb_pkg::COEF_W-1:0]    cfg_data
);

  // configuration
  logic [fcrb_pkg::RAD_W-1:0]     radius_r;
  logic [fcrb_pkg::MODE_W-1:0]    border_r;
  fcrb_pkg::coef_arr_t            coef_r;
  logic [fcrb_pkg::CFG_IDX_W-1:0] coef_idx;

  // row state and issue register
  fcrb_pkg::window_t              win_r, win_nxt;
  logic [fcrb_pkg::CNT_W-1:0]     cnt_r, cnt_nxt, cnt_inc, cnt_dec, r_ext;
  logic [fcrb_pkg::PEND_W-1:0]    pend_r, pend_nxt;
  logic [fcrb_pkg::RAD_W-1:0]     e_r, e_nxt;
  logic [fcrb_pkg::CNT_W-1:0]     job_n_r, job_n_nxt;
  logic                           job_closed_r, job_closed_nxt;
  logic                           job_short_r, job_short_nxt;
  logic [fcrb_pkg::RAD_W-1:0]     job_r_r, job_r_nxt;
  logic [fcrb_pkg::RAD_W-1:0]     r_cap;
  logic                           in_acc;
  logic                           issue;

  // tap-pair register
  fcrb_pkg::psum_arr_t            psum;
  fcrb_pkg::psum_arr_t            a_psum_r;
  fcrb_pkg::fcrb_tag_t            a_tag_r, issue_tag;
  logic                           a_valid_r;
  logic                           a_ready;
  logic                           mac_ready;
  fcrb_pkg::fcrb_tag_t            out_tag;

  assign cfg_ready = 1'b1;
  assign coef_idx  = cfg_index - fcrb_pkg::CFG_IDX_W'(fcrb_pkg::CFG_COEF0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= '0;
      border_r <= fcrb_pkg::BORDER_ZERO;
      coef_r   <= fcrb_pkg::COEF_RESET;
    end else if (cfg_valid) begin
      case (fcrb_pkg::cfg_idx_t'(cfg_index))
        fcrb_pkg::CFG_RADIUS: radius_r <= cfg_data[fcrb_pkg::RAD_W-1:0];
        fcrb_pkg::CFG_BORDER: border_r <= cfg_data[fcrb_pkg::MODE_W-1:0];
        fcrb_pkg::CFG_COEF0, fcrb_pkg::CFG_COEF1, fcrb_pkg::CFG_COEF2,
        fcrb_pkg::CFG_COEF3, fcrb_pkg::CFG_COEF4, fcrb_pkg::CFG_COEF5: begin
          coef_r[coef_idx] <= cfg_data;
        end
        default: ;
      endcase
    end
  end

  assign r_cap = (radius_r > fcrb_pkg::RAD_W'(fcrb_pkg::RAD_CAP))
               ? fcrb_pkg::RAD_W'(fcrb_pkg::RAD_CAP) : radius_r;

  assign a_ready   = !a_valid_r || mac_ready;
  assign issue     = (pend_r != '0) && a_ready;
  // next word may come in on the cycle the last pending result issues
  assign in_tready = (pend_r == '0) || ((pend_r == fcrb_pkg::PEND_W'(1)) && a_ready);
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    cnt_inc = (cnt_r < fcrb_pkg::CNT_W'(fcrb_pkg::MAX_ROW))
            ? cnt_r + fcrb_pkg::CNT_W'(1) : cnt_r;
    cnt_dec = cnt_inc - fcrb_pkg::CNT_W'(1);
    r_ext   = fcrb_pkg::CNT_W'(r_cap);

    win_nxt        = win_r;
    cnt_nxt        = cnt_r;
    pend_nxt       = pend_r;
    e_nxt          = e_r;
    job_n_nxt      = job_n_r;
    job_closed_nxt = job_closed_r;
    job_short_nxt  = job_short_r;
    job_r_nxt      = job_r_r;

    if (in_acc) begin
      win_nxt        = {win_r[fcrb_pkg::WIN_LEN-2:0], in_tdata};
      job_n_nxt      = cnt_inc;
      job_closed_nxt = in_tlast;
      job_short_nxt  = 1'b0;
      job_r_nxt      = r_cap;
      if (in_tlast) begin
        cnt_nxt = '0;
        if (cnt_inc < r_ext) begin
          pend_nxt      = fcrb_pkg::PEND_W'(1);
          e_nxt         = '0;
          job_short_nxt = 1'b1;
        end else if (cnt_dec < r_ext) begin
          // flush starts at the first sample of the row
          e_nxt    = cnt_dec[fcrb_pkg::RAD_W-1:0];
          pend_nxt = fcrb_pkg::PEND_W'(cnt_dec[fcrb_pkg::RAD_W-1:0]) + fcrb_pkg::PEND_W'(1);
        end else begin
          e_nxt    = r_cap;
          pend_nxt = fcrb_pkg::PEND_W'(r_cap) + fcrb_pkg::PEND_W'(1);
        end
      end else begin
        cnt_nxt = cnt_inc;
        e_nxt   = r_cap;
        if (cnt_inc > r_ext) begin
          pend_nxt = fcrb_pkg::PEND_W'(1);
        end else begin
          pend_nxt = '0;
        end
      end
    end else if (issue) begin
      pend_nxt = pend_r - fcrb_pkg::PEND_W'(1);
      e_nxt    = e_r - fcrb_pkg::RAD_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r  <= '0;
      cnt_r  <= '0;
      pend_r <= '0;
    end else begin
      win_r  <= win_nxt;
      cnt_r  <= cnt_nxt;
      pend_r <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    e_r          <= e_nxt;
    job_n_r      <= job_n_nxt;
    job_closed_r <= job_closed_nxt;
    job_short_r  <= job_short_nxt;
    job_r_r      <= job_r_nxt;
  end

  fcrb_tap_sel u_tap_sel (
    .win    (win_r),
    .n      (job_n_r),
    .e      (e_r),
    .closed (job_closed_r),
    .r      (job_r_r),
    .mode   (border_r),
    .psum   (psum)
  );

  assign issue_tag.last      = job_closed_r && (e_r == '0);
  assign issue_tag.short_row = job_short_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (a_ready) begin
      a_valid_r <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      a_psum_r <= psum;
      a_tag_r  <= issue_tag;
    end
  end

  fcrb_mac u_mac (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_valid  (a_valid_r),
    .s_ready  (mac_ready),
    .s_psum   (a_psum_r),
    .s_tag    (a_tag_r),
    .coef     (coef_r),
    .m_valid  (out_tvalid),
    .m_ready  (out_tready),
    .m_sample (out_tdata),
    .m_tag    (out_tag)
  );

  assign out_tlast = out_tag.last;
  assign out_tuser = out_tag.short_row;

endmodule

// ===== src/fcrb_checker.sv =====
// ----------------------------------------------------------------------------
// fcrb_checker
// port-level checks of the filter result stream, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "fir_convolution_reflect_border_macros.svh"

module fcrb_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [fcrb_pkg::SAMPLE_W-1:0]  out_tdata,
  input logic                           out_tlast,
  input logic                           out_tuser
);

  // a stalled word stays put
  `FCRB_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tlast) && $stable(out_tuser), "result word changed while stalled")

  // a short-row word closes its row
  `FCRB_ASSERT_NOW(a_short_last, out_tvalid && out_tuser, out_tlast, "short-row word without tlast")

  `FCRB_ASSERT_NOW(a_short_zero, out_tvalid && out_tuser, out_tdata == '0, "short-row word with nonzero data")

  // nothing leaves right after reset
  `FCRB_ASSERT_NEXT_ALWAYS(a_reset_idle, !rst_n, !out_tvalid, "result valid after reset")

endmodule

bind fir_convolution_reflect_border fcrb_checker u_fcrb_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);

// ===== tb/fir_convolution_reflect_border_tb.sv =====
// ----------------------------------------------------------------------------
// fir_convolution_reflect_border_tb
// self-checking bench for the reflected-border symmetric fir row filter
// ----------------------------------------------------------------------------
// A behavioral copy of the filter predicts every output word from the sample
// words and register writes seen on the ports. Directed rows cover the value
// extremes, each border mode, short rows, too-large radius and a radius change
// inside a row. Random rows follow, with random settings, random gaps on the
// sample side and random stalls on the result side. A long output stall backs
// up the input along the way.
`timescale 1ns / 1ps

module fir_convolution_reflect_border_tb;

  localparam int LIMIT_CYCLES = 1_000_000;
  localparam int SETTLE       = 12;
  localparam int RANDOM_WORDS = 250;
  localparam int LONG_HOLD    = 200;

  typedef struct packed {
    logic signed [fcrb_pkg::SAMPLE_W-1:0] value;
    logic                                 last;
    logic                                 short_row;
  } filtered_word_t;

  // behavioral copy of the row filter plus the queue of words it still owes
  class row_filter_tracker;
    logic signed [fcrb_pkg::SAMPLE_W-1:0] taps_win [fcrb_pkg::WIN_LEN];
    int                                   row_count;
    logic [fcrb_pkg::RAD_W-1:0]           radius;
    logic [fcrb_pkg::MODE_W-1:0]          border;
    logic [fcrb_pkg::COEF_W-1:0]          coef [fcrb_pkg::NCOEF];
    filtered_word_t                       owed_q [$];
    int mismatches, checked, noted, rows, short_rows;

    function new();
      foreach (taps_win[i]) taps_win[i] = '0;
      foreach (coef[i]) coef[i] = fcrb_pkg::COEF_RESET[i];
      row_count = 0;
      radius    = '0;
      border    = fcrb_pkg::BORDER_ZERO;
    endfunction

    function int pending();
      return owed_q.size();
    endfunction

    function void owe_word(filtered_word_t w);
      owed_q.insert(owed_q.size(), w);
    endfunction

    function void write_reg(fcrb_pkg::cfg_idx_t idx, logic [fcrb_pkg::COEF_W-1:0] data);
      case (idx)
        fcrb_pkg::CFG_RADIUS: radius = data[fcrb_pkg::RAD_W-1:0];
        fcrb_pkg::CFG_BORDER: border = data[fcrb_pkg::MODE_W-1:0];
        default:              coef[idx - fcrb_pkg::CFG_COEF0] = data;
      endcase
    endfunction

    function longint pad_sign();
      case (border)
        fcrb_pkg::BORDER_MIRROR: return 1;
        fcrb_pkg::BORDER_NEGATE: return -1;
        default:                 return 0;
      endcase
    endfunction

    // sample at row position p with n samples held; len is 0 while the row is open
    function longint tap_at(int p, int n, int len);
      longint sgn = 1;
      int     off;
      if (p < 0) begin
        p   = -1 - p;
        sgn = pad_sign();
      end else if (len > 0 && p >= len) begin
        p   = 2 * len - 1 - p;
        sgn = pad_sign();
      end
      off = n - 1 - p;
      if (off < 0 || off >= fcrb_pkg::WIN_LEN) return 0;
      return sgn * longint'(taps_win[off]);
    endfunction

    function logic [fcrb_pkg::SAMPLE_W-1:0] filter_at(int j, int n, int len, int r);
      longint acc;
      longint y;
      int     a;
      acc = 0;
      for (int k = -r; k <= r; k++) begin
        a = (k < 0) ? -k : k;
        acc += longint'({48'd0, coef[a]}) * tap_at(j + k, n, len);
      end
      y = (acc + fcrb_pkg::ROUND_BIAS) >>> fcrb_pkg::FRAC_W;
      if (y > fcrb_pkg::SAT_MAX) y = fcrb_pkg::SAT_MAX;
      if (y < fcrb_pkg::SAT_MIN) y = fcrb_pkg::SAT_MIN;
      return y[fcrb_pkg::SAMPLE_W-1:0];
    endfunction

    function void note_sample(logic [fcrb_pkg::SAMPLE_W-1:0] s, logic row_end);
      int             r;
      int             n;
      int             first;
      filtered_word_t w;
      noted++;
      r = (int'(radius) > fcrb_pkg::RAD_CAP) ? fcrb_pkg::RAD_CAP : int'(radius);
      for (int i = fcrb_pkg::WIN_LEN - 1; i > 0; i--) taps_win[i] = taps_win[i-1];
      taps_win[0] = s;
      if (row_count < fcrb_pkg::MAX_ROW) row_count++;
      n = row_count;
      w.short_row = 1'b0;
      if (!row_end) begin
        if (n - 1 - r >= 0) begin
          w.value = filter_at(n - 1 - r, n, 0, r);
          w.last  = 1'b0;
          owe_word(w);
        end
        return;
      end
      row_count = 0;
      rows++;
      if (n < r) begin
        w.value     = '0;
        w.last      = 1'b1;
        w.short_row = 1'b1;
        owe_word(w);
        short_rows++;
        return;
      end
      // row end: flush the held-back outputs in order
      first = (n - 1 - r < 0) ? 0 : n - 1 - r;
      for (int j = first; j <= n - 1; j++) begin
        w.value = filter_at(j, n, n, r);
        w.last  = (j == n - 1);
        owe_word(w);
      end
    endfunction

    function void flag(string what, int exp_v, int got_v);
      mismatches++;
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, exp_v, got_v);
    endfunction

    function void check_word(logic [fcrb_pkg::SAMPLE_W-1:0] data, logic last,
                             logic short_row);
      filtered_word_t w;
      checked++;
      if (owed_q.size() == 0) begin
        mismatches++;
        $display("%0t ns: result word with nothing pending, expected none, actual %0d",
                 $time, $signed(data));
        return;
      end
      w = owed_q.pop_front();
      if (data !== w.value) flag("sample_out", w.value, $signed(data));
      if (last !== w.last) flag("last_out", w.last, last);
      if (short_row !== w.short_row) flag("short_row", w.short_row, short_row);
    endfunction
  endclass

  logic                           clk;
  logic                           rst_n;
  logic                           in_tvalid;
  logic                           in_tready;
  logic [fcrb_pkg::SAMPLE_W-1:0]  in_tdata;
  logic                           in_tlast;
  logic                           out_tvalid;
  logic                           out_tready;
  logic [fcrb_pkg::SAMPLE_W-1:0]  out_tdata;
  logic                           out_tlast;
  logic                           out_tuser;
  logic                           cfg_valid;
  logic                           cfg_ready;
  fcrb_pkg::cfg_idx_t             cfg_index;
  logic [fcrb_pkg::COEF_W-1:0]    cfg_data;

  row_filter_tracker tracker = new();
  int cycle_count = 0;
  int settings_used = 0;
  bit no_idle = 1'b0;
  bit long_hold_req = 1'b0;

  fir_convolution_reflect_border DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // port monitor: every handshake feeds the tracker
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) tracker.write_reg(cfg_index, cfg_data);
      if (in_tvalid && in_tready) tracker.note_sample(in_tdata, in_tlast);
      if (out_tvalid && out_tready) tracker.check_word(out_tdata, out_tlast, out_tuser);
    end
  end

  // result side: ready bursts and stalls, plus one long hold-off on request
  initial begin
    out_tready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (long_hold_req) begin
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold_req = 1'b0;
      end else if (no_idle || $urandom_range(0, 2) != 0) begin
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else begin
        out_tready <= 1'b0;
        if ($urandom_range(0, 4) == 0) repeat ($urandom_range(10, 40)) @(posedge clk);
        else repeat ($urandom_range(1, 3)) @(posedge clk);
      end
    end
  end

  function automatic logic [fcrb_pkg::SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return 16'h7fff;
      1:       return 16'h8000;
      2:       return 16'h0000;
      3:       return fcrb_pkg::SAMPLE_W'($urandom_range(0, 1023) - 512);
      default: return fcrb_pkg::SAMPLE_W'($urandom);
    endcase
  endfunction

  function automatic int pick_gap();
    int roll;
    if (no_idle) return 0;
    roll = $urandom_range(0, 9);
    if (roll < 6) return 0;
    if (roll < 9) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic int pick_row_len();
    case ($urandom_range(0, 9))
      0:          return $urandom_range(1, 2);
      7, 8:       return $urandom_range(13, 30);
      9:          return $urandom_range(31, 60);
      default:    return $urandom_range(3, 12);
    endcase
  endfunction

  function automatic fcrb_pkg::coef_arr_t pick_coefs();
    fcrb_pkg::coef_arr_t c;
    int                  style;
    style = $urandom_range(0, 5);
    for (int i = 0; i < fcrb_pkg::NCOEF; i++) begin
      case (style)
        0:       c[i] = 16'hffff;
        1:       c[i] = 16'h0000;
        2:       c[i] = fcrb_pkg::COEF_W'($urandom);
        default: c[i] = fcrb_pkg::COEF_W'($urandom_range(0, 16383));
      endcase
    end
    return c;
  endfunction

  task automatic put_word(input logic [fcrb_pkg::SAMPLE_W-1:0] s, input logic row_end,
                          input int gap);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= s;
    in_tlast  <= row_end;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic send_row(input int len, input bit close_row, input bit use_gaps);
    for (int i = 0; i < len; i++)
      put_word(pick_sample(), close_row && (i == len - 1), use_gaps ? pick_gap() : 0);
  endtask

  task automatic put_reg(input fcrb_pkg::cfg_idx_t idx,
                         input logic [fcrb_pkg::COEF_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic load_settings(input logic [fcrb_pkg::COEF_W-1:0] rad,
                               input logic [fcrb_pkg::COEF_W-1:0] mode,
                               input fcrb_pkg::coef_arr_t c);
    put_reg(fcrb_pkg::CFG_RADIUS, rad);
    put_reg(fcrb_pkg::CFG_BORDER, mode);
    for (int i = 0; i < fcrb_pkg::NCOEF; i++)
      put_reg(fcrb_pkg::cfg_idx_t'(fcrb_pkg::CFG_COEF0 + i), c[i]);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  // hold off until every owed word is out and the pipeline has gone quiet
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  initial begin
    fcrb_pkg::coef_arr_t cset;
    int                  sent;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tlast  <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= fcrb_pkg::CFG_RADIUS;
    cfg_data  <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: single tap just under unity gain
    put_word(16'h7fff, 1'b0, pick_gap());
    put_word(16'h8000, 1'b0, pick_gap());
    put_word(16'h0001, 1'b1, pick_gap());
    wait_idle();

    // mirrored borders, extremes at both row ends
    cset = {16'h0000, 16'h0000, 16'h0000, 16'h1000, 16'h3000, 16'h8000};
    load_settings(16'd2, fcrb_pkg::BORDER_MIRROR, cset);
    put_word(16'h7fff, 1'b0, 0);
    put_word(16'h7fff, 1'b0, 0);
    put_word(16'h8000, 1'b0, 0);
    put_word(16'h8000, 1'b1, 0);
    wait_idle();

    // negated mirror
    load_settings(16'd2, fcrb_pkg::BORDER_NEGATE, cset);
    put_word(16'h0100, 1'b0, pick_gap());
    put_word(16'hff00, 1'b0, pick_gap());
    put_word(16'h7fff, 1'b1, pick_gap());
    wait_idle();

    // unused border code pads with zeros; full weights saturate both ways
    load_settings(16'd5, 16'd3, {fcrb_pkg::NCOEF{16'hffff}});
    for (int i = 0; i < 6; i++) put_word((i < 3) ? 16'h7fff : 16'h8000, i == 5, 0);
    wait_idle();

    // radius above the limit, row shorter than the radius
    load_settings(16'd7, fcrb_pkg::BORDER_MIRROR, pick_coefs());
    for (int i = 0; i < 3; i++) put_word(pick_sample(), i == 2, pick_gap());
    wait_idle();

    // row exactly as long as the radius
    load_settings(16'd4, fcrb_pkg::BORDER_MIRROR, pick_coefs());
    for (int i = 0; i < 4; i++) put_word(pick_sample(), i == 3, pick_gap());
    wait_idle();

    // radius change in the middle of an open row
    load_settings(16'd1, fcrb_pkg::BORDER_ZERO, pick_coefs());
    send_row(3, 1'b0, 1'b1);
    wait_idle();
    load_settings(16'd3, fcrb_pkg::BORDER_NEGATE, pick_coefs());
    send_row(3, 1'b1, 1'b1);
    wait_idle();

    // back-to-back rows against a long output stall so the input backs up
    load_settings(16'd3, fcrb_pkg::BORDER_MIRROR, pick_coefs());
    long_hold_req = 1'b1;
    for (int i = 0; i < 48; i++) put_word(pick_sample(), (i % 8) == 7, 0);
    wait_idle();

    // random settings and rows; some phases leave a row open across the change
    sent = 0;
    while (sent < RANDOM_WORDS) begin
      int len;
      no_idle = ($urandom_range(0, 5) == 0);
      load_settings({13'($urandom), 3'($urandom_range(0, 7))},
                    {14'($urandom), 2'($urandom_range(0, 3))}, pick_coefs());
      repeat ($urandom_range(1, 4)) begin
        len = pick_row_len();
        send_row(len, 1'b1, 1'b1);
        sent += len;
      end
      if ($urandom_range(0, 3) == 0) begin
        len = $urandom_range(1, 6);
        send_row(len, 1'b0, 1'b1);
        sent += len;
      end
      wait_idle();
    end
    no_idle = 1'b0;

    $display("covered %0d sample words in %0d rows (%0d too short), %0d result words checked",
             tracker.noted, tracker.rows, tracker.short_rows, tracker.checked);
    $display("over %0d filter settings, with a %0d-cycle output stall",
             settings_used, LONG_HOLD);
    if (tracker.mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
